FILE: rtl/bfpe_pkg.sv
// Shared types and constants for the bloom filter probe engine.
package bfpe_pkg;

	localparam int STORE_WORDS = 1024;
	localparam int MAX_PROBES = 32;
	localparam int WIDX_W = $clog2(STORE_WORDS);
	localparam int BIT_W = WIDX_W + 6;
	localparam int BITS_W = BIT_W + 1;
	localparam int PROBE_W = $clog2(MAX_PROBES + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_BITS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LOCKED = 2'd2;

	localparam logic [1:0] REQ_ADD = 2'd0;
	localparam logic [1:0] REQ_QUERY = 2'd1;
	localparam logic [1:0] REQ_MERGE = 2'd2;
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [63:0] hash_low;
		logic [63:0] hash_high;
		logic [9:0] merge_word;
		logic [63:0] word_data;
	} req_t;

	typedef struct packed {
		logic present;
		logic status;
	} rsp_t;

	// Classified job handed from front to back.
	typedef struct packed {
		logic [1:0] kind;
		logic locked;
		logic merge_ok;
		logic [63:0] base;
		logic [63:0] step;
		logic [WIDX_W-1:0] widx;
		logic [63:0] wdata;
		logic [BITS_W-1:0] count;
		logic pow2;
		logic [PROBE_W-1:0] nprobe;
	} job_t;

endpackage

FILE: rtl/bfpe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module bfpe_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/bfpe_front.sv
// Front end: clamps config, classifies items and queues jobs.
module bfpe_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input bfpe_pkg::req_t req,
	input logic [bfpe_pkg::BITS_W-1:0] cfg_bits,
	input logic [5:0] cfg_probes,
	input logic cfg_locked,
	output logic busy,
	output logic job_valid,
	output bfpe_pkg::job_t job,
	input logic job_take
);
	import bfpe_pkg::*;

	logic full_q;
	job_t job_q;
	job_t nj;
	logic [BITS_W-1:0] cnt;
	logic [PROBE_W-1:0] np;
	logic [BITS_W-1:0] words;

	always_comb begin
		cnt = cfg_bits;
		if (cfg_bits < BITS_W'(64)) cnt = BITS_W'(64);
		if (cfg_bits > BITS_W'(STORE_WORDS * 64)) cnt = BITS_W'(STORE_WORDS * 64);
		if (cfg_probes == 6'd0) np = PROBE_W'(1);
		else if (cfg_probes > 6'(MAX_PROBES)) np = PROBE_W'(MAX_PROBES);
		else np = PROBE_W'(cfg_probes);
		words = (cnt + BITS_W'(63)) >> 6;
		nj.kind = req.req_type;
		nj.locked = cfg_locked;
		nj.merge_ok = BITS_W'(req.merge_word) < words
			&& 32'(req.merge_word) < STORE_WORDS;
		nj.base = req.hash_low;
		nj.step = req.hash_high | 64'd1;
		nj.widx = WIDX_W'(req.merge_word);
		nj.wdata = req.word_data;
		nj.count = cnt;
		nj.pow2 = (cnt & (cnt - BITS_W'(1))) == '0;
		nj.nprobe = np;
	end

	assign busy = full_q;
	assign job_valid = full_q;
	assign job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (start && !busy) begin
			full_q <= 1'b1;
		end else if (job_take) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			job_q <= nj;
		end
	end
endmodule

FILE: rtl/bfpe_back.sv
// Back end: clears the store, then runs probe and merge jobs on the RAM.
module bfpe_back (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input bfpe_pkg::job_t job,
	output logic job_take,
	output logic clearing,
	output logic done,
	output bfpe_pkg::rsp_t rsp
);
	import bfpe_pkg::*;

	localparam logic [2:0] ST_CLR = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_HASH = 3'd2;
	localparam logic [2:0] ST_MUL = 3'd3;
	localparam logic [2:0] ST_READ = 3'd4;
	localparam logic [2:0] ST_CHECK = 3'd5;

	logic [2:0] state_q;
	logic [WIDX_W:0] clr_q;
	logic [PROBE_W-1:0] idx_q;
	logic [63:0] v_q;
	logic [BIT_W-1:0] bit_q;
	logic [63:0] ph_q;
	logic [63:0] pl_q;
	logic merge_q;
	logic we;
	logic [WIDX_W-1:0] waddr;
	logic [WIDX_W-1:0] raddr;
	logic [63:0] wdata;
	logic [63:0] rdata;
	logic [63:0] mask;
	logic [63:0] mh;
	logic last;

	bfpe_ram #(.WIDTH(64), .DEPTH(STORE_WORDS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign mask = 64'd1 << bit_q[5:0];
	assign mh = (ph_q + (pl_q >> 32)) >> 32;
	assign last = 32'(idx_q) + 1 >= 32'(job.nprobe);
	assign clearing = state_q == ST_CLR;
	assign raddr = merge_q ? job.widx : bit_q[BIT_W-1:6];

	always_comb begin
		we = 1'b0;
		waddr = bit_q[BIT_W-1:6];
		wdata = rdata | mask;
		if (state_q == ST_CLR) begin
			we = 1'b1;
			waddr = clr_q[WIDX_W-1:0];
			wdata = '0;
		end else if (state_q == ST_CHECK && merge_q) begin
			we = job.merge_ok;
			waddr = job.widx;
			wdata = rdata | job.wdata;
		end else if (state_q == ST_CHECK && job.kind == REQ_ADD) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			idx_q <= '0;
			v_q <= '0;
			bit_q <= '0;
			ph_q <= '0;
			pl_q <= '0;
			merge_q <= 1'b0;
			done <= 1'b0;
			job_take <= 1'b0;
			rsp <= '0;
		end else begin
			done <= 1'b0;
			job_take <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == STORE_WORDS - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (job_valid && !job_take) begin
						idx_q <= '0;
						merge_q <= 1'b0;
						v_q <= job.base;
						if (job.kind == REQ_QUERY) begin
							state_q <= ST_MUL;
						end else if ((job.kind == REQ_ADD || job.kind == REQ_MERGE)
							&& !job.locked) begin
							merge_q <= job.kind == REQ_MERGE;
							state_q <= job.kind == REQ_MERGE ? ST_READ : ST_MUL;
						end else begin
							done <= 1'b1;
							job_take <= 1'b1;
							rsp <= '{present: 1'b0,
								status: job.locked && job.kind != REQ_UNKNOWN};
						end
					end
				end
				ST_MUL: begin
					ph_q <= (v_q >> 32) * 64'(job.count);
					pl_q <= (v_q & 64'hFFFF_FFFF) * 64'(job.count);
					if (job.pow2) begin
						bit_q <= BIT_W'(v_q & 64'(job.count - 1'b1));
						state_q <= ST_READ;
					end else begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					bit_q <= BIT_W'(mh);
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				default: begin
					if (merge_q || (job.kind == REQ_QUERY && (rdata & mask) == '0)
						|| last) begin
						done <= 1'b1;
						job_take <= 1'b1;
						rsp <= '{present: job.kind == REQ_QUERY && !merge_q
							&& (rdata & mask) != '0, status: 1'b0};
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						v_q <= v_q + job.step;
						state_q <= ST_MUL;
					end
				end
			endcase
		end
	end
endmodule

FILE: rtl/bloom_filter_probe_engine.sv
// Top level of the bloom filter probe engine.
// Refused or unknown items finish straight from idle; merges read the word and then
// OR in the data; adds and queries run multiply (then hash when the bit count is not a
// power of two), read and check per probe; a query ends at its first clear bit.
// One item in flight at a time; the next may start the cycle after done.
// Reset clears the store in a sweep over all 1024 words; busy stays high meanwhile.
// Results pulse on done for one cycle; the receiver cannot stall.
module bloom_filter_probe_engine (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input bfpe_pkg::req_t req,
	output logic done,
	output bfpe_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [bfpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bfpe_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bfpe_pkg::*;

	logic [BITS_W-1:0] bits_q;
	logic [5:0] probes_q;
	logic locked_q;
	logic fbusy;
	logic job_valid;
	job_t job;
	logic job_take;
	logic clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= BITS_W'(65536);
			probes_q <= 6'd7;
			locked_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BITS_IN_USE: bits_q <= cfg_data;
				CFG_PROBE_COUNT: probes_q <= cfg_data[5:0];
				CFG_WRITE_LOCKED: locked_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign busy = fbusy || clearing;

	bfpe_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start && !clearing), .req(req),
		.cfg_bits(bits_q), .cfg_probes(probes_q), .cfg_locked(locked_q),
		.busy(fbusy), .job_valid(job_valid), .job(job), .job_take(job_take)
	);

	bfpe_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job(job),
		.job_take(job_take), .clearing(clearing), .done(done), .rsp(rsp)
	);

`ifndef SYNTH
	a_no_done_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !done) else $error("result during clear");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not held");
	a_query_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.present && rsp.status)) else $error("bad result");
`endif
endmodule
